@@ rtl/assert_macros.svh @@
// assertion macros shared by the md5 stream rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define MD5_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define MD5_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MD5_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/md5_pkg.sv @@
// types, constants and round tables of the md5 stream block
`timescale 1ns / 1ps

package md5_pkg;

  localparam int BLOCK_WORDS = 16;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LAST_POS   = 6'h3f;
  localparam logic [5:0] PAD_LIMIT  = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'h3f;

  // one 512-bit block headed for compression
  typedef struct packed {
    logic [BLOCK_WORDS-1:0][31:0] words;
    logic                         final_blk;
  } md5_job_t;

  function automatic logic [31:0] md5_round_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  // left rotate amount, four per group of sixteen rounds
  function automatic logic [4:0] md5_rot(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // message word used by round r
  function automatic logic [3:0] md5_msg_index(input logic [5:0] r);
    logic [3:0] r4;
    logic [3:0] g;
    r4 = r[3:0];
    unique case (r[5:4])
      2'd0:    g = r4;
      2'd1:    g = 4'(r4 * 4'd5 + 4'd1);
      2'd2:    g = 4'(r4 * 4'd3 + 4'd5);
      2'd3:    g = 4'(r4 * 4'd7);
      default: g = r4;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/md5_if.sv @@
// valid/ready channels for message bytes and digests
`timescale 1ns / 1ps

interface md5_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_data;
  logic       byte_valid;
  logic       is_last;

  modport source (output valid, byte_data, byte_valid, is_last, input ready);
  modport sink   (input valid, byte_data, byte_valid, is_last, output ready);
endinterface

interface md5_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word_a;
  logic [31:0] digest_word_b;
  logic [31:0] digest_word_c;
  logic [31:0] digest_word_d;

  modport source (output valid, digest_word_a, digest_word_b, digest_word_c, digest_word_d,
                  input ready);
  modport sink   (input valid, digest_word_a, digest_word_b, digest_word_c, digest_word_d,
                  output ready);
endinterface

@@ rtl/md5_front.sv @@
// byte packing, length count and padding ahead of the block queue
`timescale 1ns / 1ps
`include "assert_macros.svh"

module md5_front (
  input  logic              clk,
  input  logic              rst,
  md5_byte_if.sink          msg,
  input  logic              q_full,
  output logic              push,
  output md5_pkg::md5_job_t job
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    F_COLLECT = 3'b001,
    F_PAD     = 3'b010,
    F_LEN     = 3'b100
  } front_state_t;

  front_state_t                 state, state_next;
  logic [60:0]                  count;
  logic [BLOCK_WORDS-1:0][31:0] blk;
  logic [BLOCK_WORDS-1:0][31:0] blk_byte, blk_pad, blk_len;
  logic [5:0]                   pos;
  logic                         pad_wrap;
  logic                         accept;
  logic [31:0]                  len_lo, len_hi;

  // write one byte lane, lanes above it cleared
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] v);
    logic [31:0] keep;
    case (lane)
      2'd0:    keep = 32'h00000000;
      2'd1:    keep = 32'h000000ff;
      2'd2:    keep = 32'h0000ffff;
      default: keep = 32'h00ffffff;
    endcase
    return (w & keep) | ({24'd0, v} << {lane, 3'b000});
  endfunction

  assign pos       = count[5:0];
  assign pad_wrap  = (pos >= PAD_LIMIT);
  assign accept    = msg.valid && msg.ready;
  assign msg.ready = (state == F_COLLECT) && !q_full;
  assign len_lo    = {count[28:0], 3'b000};
  assign len_hi    = count[60:29];

  always_comb begin
    blk_byte = blk;
    blk_byte[pos[5:2]] = put_byte(blk[pos[5:2]], pos[1:0], msg.byte_data);
  end

  always_comb begin
    blk_pad = blk;
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      if (4'(i) > pos[5:2]) begin
        blk_pad[i] = '0;
      end
    end
    blk_pad[pos[5:2]] = put_byte(blk[pos[5:2]], pos[1:0], PAD_BYTE);
    if (!pad_wrap) begin
      blk_pad[14] = len_lo;
      blk_pad[15] = len_hi;
    end
  end

  always_comb begin
    blk_len = '0;
    blk_len[14] = len_lo;
    blk_len[15] = len_hi;
  end

  always_comb begin
    push          = 1'b0;
    job.words     = blk_byte;
    job.final_blk = 1'b0;
    state_next    = state;
    unique case (state)
      F_COLLECT: begin
        if (accept) begin
          if (msg.byte_valid && pos == LAST_POS) begin
            push = 1'b1;
          end
          if (msg.is_last) begin
            state_next = F_PAD;
          end
        end
      end
      F_PAD: begin
        job.words     = blk_pad;
        job.final_blk = !pad_wrap;
        if (!q_full) begin
          push       = 1'b1;
          state_next = pad_wrap ? F_LEN : F_COLLECT;
        end
      end
      F_LEN: begin
        job.words     = blk_len;
        job.final_blk = 1'b1;
        if (!q_full) begin
          push       = 1'b1;
          state_next = F_COLLECT;
        end
      end
      default: state_next = F_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_COLLECT;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept && msg.byte_valid) begin
        count <= 61'(count + 61'd1);
      end
      if (push && job.final_blk) begin
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && msg.byte_valid) begin
      blk <= blk_byte;
    end
  end

  `MD5_ASSERT_NEXT(a_count_clear, push && job.final_blk, count == 61'd0, "count not cleared")

endmodule

@@ rtl/md5_queue.sv @@
// two-entry block queue between packing front and compression core
`timescale 1ns / 1ps
`include "assert_macros.svh"

module md5_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  md5_pkg::md5_job_t wr_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output md5_pkg::md5_job_t head
);
  import md5_pkg::*;

  md5_job_t             slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [Q_PTR_W:0]     fill;

  assign full       = (fill == (Q_PTR_W + 1)'(Q_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= Q_PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= Q_PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= (Q_PTR_W + 1)'(fill + 1'b1);
      end else if (pop && !push) begin
        fill <= (Q_PTR_W + 1)'(fill - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  `MD5_ASSERT(a_no_overflow, !(push && full), "push into full queue")
  `MD5_ASSERT(a_no_underflow, !(pop && !head_valid), "pop from empty queue")

endmodule

@@ rtl/md5_core.sv @@
// 64-round compression, one round per cycle, and digest output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module md5_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  md5_pkg::md5_job_t head,
  output logic              pop,
  md5_digest_if.source      digest
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE   = 3'b001,
    C_RUN    = 3'b010,
    C_FINISH = 3'b100
  } core_state_t;

  core_state_t  state;
  logic [5:0]   rnd;
  logic [31:0]  a, b, c, d;
  logic [31:0]  ha, hb, hc, hd;
  logic [31:0]  f, m, sum, b_new;
  logic [31:0]  sum_a, sum_b, sum_c, sum_d;
  logic [31:0]  out_a, out_b, out_c, out_d;
  logic         out_valid;
  logic         out_free;
  logic         emit;
  logic         run_step;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
  end

  assign m     = head.words[md5_msg_index(rnd)];
  assign sum   = a + f + md5_round_const(rnd) + m;
  assign b_new = b + rotl(sum, md5_rot(rnd));

  assign sum_a = ha + a;
  assign sum_b = hb + b;
  assign sum_c = hc + c;
  assign sum_d = hd + d;

  assign out_free = !out_valid || digest.ready;
  assign pop      = (state == C_FINISH) && (!head.final_blk || out_free);
  assign emit     = pop && head.final_blk;
  assign run_step = (state == C_RUN) && (rnd != ROUND_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      rnd       <= '0;
      out_valid <= 1'b0;
      ha        <= INIT_A;
      hb        <= INIT_B;
      hc        <= INIT_C;
      hd        <= INIT_D;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (digest.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        C_IDLE: begin
          if (head_valid) begin
            rnd   <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          rnd <= 6'(rnd + 6'd1);
          if (rnd == ROUND_LAST) begin
            state <= C_FINISH;
          end
        end
        C_FINISH: begin
          if (pop) begin
            state <= C_IDLE;
            if (head.final_blk) begin
              ha <= INIT_A;
              hb <= INIT_B;
              hc <= INIT_C;
              hd <= INIT_D;
            end else begin
              ha <= sum_a;
              hb <= sum_b;
              hc <= sum_c;
              hd <= sum_d;
            end
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // working words and digest payload
  always_ff @(posedge clk) begin
    if (state == C_IDLE) begin
      a <= ha;
      b <= hb;
      c <= hc;
      d <= hd;
    end else if (state == C_RUN) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b_new;
    end
    if (emit) begin
      out_a <= sum_a;
      out_b <= sum_b;
      out_c <= sum_c;
      out_d <= sum_d;
    end
  end

  assign digest.valid         = out_valid;
  assign digest.digest_word_a = out_a;
  assign digest.digest_word_b = out_b;
  assign digest.digest_word_c = out_c;
  assign digest.digest_word_d = out_d;

  `MD5_ASSERT_NEXT(a_round_step, run_step, state == C_RUN && rnd == $past(rnd) + 6'd1, "round skip")
  `MD5_ASSERT_IMPL(a_digest_src, $rose(out_valid), $past(state == C_FINISH), "early digest")

endmodule

@@ rtl/md5_hash_stream.sv @@
// streaming md5 digest: one message byte per request, one digest per message
// blocks: a full block is queued on its 64th byte; compression is a load step,
// 64 rounds of the single round unit and a chaining add step
// throughput: one byte per cycle while the two-entry block queue has room and the
// front is collecting; the last request adds 1 to 2 pad blocks
// reset: synchronous, clears count, queue and fsms and loads the md5 initial words
`timescale 1ns / 1ps

module md5_hash_stream (
  input  logic         clk,
  input  logic         rst,
  md5_byte_if.sink     msg,
  md5_digest_if.source digest
);
  import md5_pkg::*;

  // front to queue
  logic     push;
  md5_job_t wr_job;
  logic     q_full;

  // queue to core
  logic     head_valid;
  md5_job_t head;
  logic     pop;

  // front: packs bytes little-endian, counts the length and builds pad blocks
  md5_front u_front (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .q_full (q_full),
    .push   (push),
    .job    (wr_job)
  );

  // queue: lets the front fill the next block while the core compresses
  md5_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_job     (wr_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // core: chaining words, round unit and the digest output register
  md5_core u_core (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .digest     (digest)
  );

endmodule
